FILE: design/mtpd_pkg.sv
package mtpd_pkg;

	// default sizes
	localparam int STORE_DEPTH_DEF = 4096;
	localparam int TAP_COUNT_DEF   = 4;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int LEN_BITS   = 13;
	localparam int FIELD_BITS = 16;
	localparam int CFG_BITS   = 64;
	localparam int ADDR_BITS  = 5;
	localparam int TAP_BITS   = 2;

	// arithmetic constants
	localparam int PAN_FULL    = 32768;
	localparam int PAN_SHIFT   = 15;
	localparam int ROUND_SHIFT = 29;

	localparam logic [LEN_BITS-1:0] LEN_RESET = 13'd4096;

	// register index, paddr[4:3]
	typedef enum logic [1:0] {
		REG_BUFFER_LENGTH,
		REG_TAP_DELAYS,
		REG_TAP_GAINS,
		REG_TAP_PANS
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_BITS-1:0] buffer_length;
		logic [CFG_BITS-1:0] tap_delays;
		logic [CFG_BITS-1:0] tap_gains;
		logic [CFG_BITS-1:0] tap_pans;
	} cfg_t;

	// control of the shared multiply unit
	typedef struct packed {
		logic clr;
		logic mul_gain;
		logic mul_pan;
		logic form;
	} mac_ctrl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL_GAIN,
		ST_MUL_PAN,
		ST_FORM,
		ST_DONE
	} state_t;

endpackage

FILE: design/mtpd_if.sv
// mono sample channel
interface mtpd_in_if #(
	parameter int SAMPLE_BITS = mtpd_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// stereo result channel
interface mtpd_out_if #(
	parameter int SAMPLE_BITS = mtpd_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          clipped;

	modport source (output valid, output left_out, output right_out, output clipped,
		input ready);
	modport sink (input valid, input left_out, input right_out, input clipped,
		output ready);
endinterface

FILE: design/mtpd_regs.sv
module mtpd_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mtpd_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [mtpd_pkg::CFG_BITS-1:0]     pwdata,
	output logic [mtpd_pkg::CFG_BITS-1:0]     prdata,
	output logic                              pready,
	output mtpd_pkg::cfg_t                    cfg
);

	mtpd_pkg::cfg_t   cfg_q;
	mtpd_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = mtpd_pkg::reg_idx_t'(paddr[4:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_length <= mtpd_pkg::LEN_RESET;
			cfg_q.tap_delays    <= '0;
			cfg_q.tap_gains     <= '0;
			cfg_q.tap_pans      <= '0;
		end else if (wr_en) begin
			case (idx)
				mtpd_pkg::REG_BUFFER_LENGTH: begin
					cfg_q.buffer_length <= pwdata[mtpd_pkg::LEN_BITS-1:0];
				end
				mtpd_pkg::REG_TAP_DELAYS: cfg_q.tap_delays <= pwdata;
				mtpd_pkg::REG_TAP_GAINS:  cfg_q.tap_gains  <= pwdata;
				mtpd_pkg::REG_TAP_PANS:   cfg_q.tap_pans   <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			mtpd_pkg::REG_BUFFER_LENGTH: begin
				prdata = mtpd_pkg::CFG_BITS'(cfg_q.buffer_length);
			end
			mtpd_pkg::REG_TAP_DELAYS: prdata = cfg_q.tap_delays;
			mtpd_pkg::REG_TAP_GAINS:  prdata = cfg_q.tap_gains;
			mtpd_pkg::REG_TAP_PANS:   prdata = cfg_q.tap_pans;
			default:                  prdata = '0;
		endcase
	end

endmodule

FILE: design/mtpd_store.sv
module mtpd_store #(
	parameter int STORE_DEPTH = mtpd_pkg::STORE_DEPTH_DEF,
	parameter int SAMPLE_BITS = mtpd_pkg::SAMPLE_BITS_DEF,
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [SAMPLE_BITS-1:0] wdata,
	input  logic [AW-1:0]          raddr,
	output logic [SAMPLE_BITS-1:0] rdata
);

	logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
	logic [SAMPLE_BITS-1:0] rdata_q;

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/mtpd_mac.sv
module mtpd_mac #(
	parameter int SAMPLE_BITS = mtpd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  mtpd_pkg::mac_ctrl_t           ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [mtpd_pkg::FIELD_BITS-1:0] gain,
	input  logic [mtpd_pkg::FIELD_BITS-1:0] pan,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          clipped
);

	localparam int FB    = mtpd_pkg::FIELD_BITS;
	localparam int SGW   = SAMPLE_BITS + FB;
	localparam int BW    = FB + 1;
	localparam int PW    = SGW + BW;
	localparam int SUMW  = SGW + 2;
	localparam int ACCRW = SGW + 18;
	localparam int ACC_W = SGW + 19;
	localparam int RW    = ACC_W + 1 - mtpd_pkg::ROUND_SHIFT;

	localparam logic signed [ACC_W:0] HALF =
		(ACC_W + 1)'(1) <<< (mtpd_pkg::ROUND_SHIFT - 1);
	localparam logic signed [RW-1:0] MAXV = RW'((1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);
	localparam logic [FB-1:0] PAN_MAX = FB'(mtpd_pkg::PAN_FULL);

	logic signed [SGW-1:0]   op_a;
	logic signed [BW-1:0]    op_b;
	logic signed [PW-1:0]    prod;
	logic [FB-1:0]           pan_c;
	logic signed [SGW-1:0]   sg_q;
	logic signed [SUMW-1:0]  sumsg_q;
	logic signed [ACCRW-1:0] accr_q;
	logic signed [ACC_W-1:0] accl_q;
	logic signed [ACC_W:0]   tl;
	logic signed [ACC_W:0]   tr;
	logic signed [RW-1:0]    rl;
	logic signed [RW-1:0]    rr;
	logic                    sat_l;
	logic                    sat_r;

	// pan clamp to full right
	assign pan_c = (pan > PAN_MAX) ? PAN_MAX : pan;

	// the one shared multiplier
	always_comb begin
		if (ctrl.mul_pan) begin
			op_a = sg_q;
			op_b = $signed({1'b0, pan_c});
		end else begin
			op_a = {{FB{sample[SAMPLE_BITS-1]}}, sample};
			op_b = $signed({gain[FB-1], gain});
		end
	end

	assign prod = PW'(op_a) * PW'(op_b);

	// accumulators: right sums sg*pan, left is sum(sg)*full minus right
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			sumsg_q <= '0;
			accr_q  <= '0;
		end else if (ctrl.mul_pan) begin
			sumsg_q <= sumsg_q + SUMW'(sg_q);
			accr_q  <= accr_q + ACCRW'(prod);
		end
		if (ctrl.mul_gain) begin
			sg_q <= prod[SGW-1:0];
		end
		if (ctrl.form) begin
			accl_q <= (ACC_W'(sumsg_q) <<< mtpd_pkg::PAN_SHIFT) - ACC_W'(accr_q);
		end
	end

	// round half up and saturate
	always_comb begin
		tl = (ACC_W + 1)'(accl_q) + HALF;
		tr = (ACC_W + 1)'(accr_q) + HALF;
		rl = RW'(tl >>> mtpd_pkg::ROUND_SHIFT);
		rr = RW'(tr >>> mtpd_pkg::ROUND_SHIFT);
		sat_l = (rl > MAXV) || (rl < MINV);
		sat_r = (rr > MAXV) || (rr < MINV);
		if (rl > MAXV) begin
			left_out = MAXV[SAMPLE_BITS-1:0];
		end else if (rl < MINV) begin
			left_out = MINV[SAMPLE_BITS-1:0];
		end else begin
			left_out = rl[SAMPLE_BITS-1:0];
		end
		if (rr > MAXV) begin
			right_out = MAXV[SAMPLE_BITS-1:0];
		end else if (rr < MINV) begin
			right_out = MINV[SAMPLE_BITS-1:0];
		end else begin
			right_out = rr[SAMPLE_BITS-1:0];
		end
		clipped = sat_l || sat_r;
	end

endmodule

FILE: design/multitap_panned_delay.sv
// no new item is taken until the last result is loaded into the output register;
// each tap takes a store read, a sample-by-gain multiply and a by-pan multiply
//   on the one shared multiplier
// reset: arst_n clears control and registers, then a clearing pass zeroes the store,
//   one entry a cycle over all STORE_DEPTH entries, with no item taken meanwhile
module multitap_panned_delay #(
	parameter int STORE_DEPTH = mtpd_pkg::STORE_DEPTH_DEF,
	parameter int TAP_COUNT   = mtpd_pkg::TAP_COUNT_DEF,
	parameter int SAMPLE_BITS = mtpd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mtpd_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [mtpd_pkg::CFG_BITS-1:0]     pwdata,
	output logic [mtpd_pkg::CFG_BITS-1:0]     prdata,
	output logic                              pready,
	mtpd_in_if.sink                           sample,
	mtpd_out_if.source                        mix
);

	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int LB    = mtpd_pkg::LEN_BITS;
	localparam int DEP_W = $clog2(STORE_DEPTH + 1);
	localparam int LEN_W = (DEP_W > LB) ? DEP_W : LB;
	localparam int FB    = mtpd_pkg::FIELD_BITS;
	localparam int CMP_W = (LEN_W > FB) ? LEN_W : FB;
	localparam int TB    = mtpd_pkg::TAP_BITS;
	localparam logic [AW-1:0]    CLR_LAST = AW'(STORE_DEPTH - 1);
	localparam logic [LEN_W-1:0] DEPTH_L  = LEN_W'(STORE_DEPTH);
	localparam logic [TB-1:0]    TAP_LAST = TB'(TAP_COUNT - 1);

	mtpd_pkg::cfg_t      cfg;
	mtpd_pkg::state_t    state_q, state_d;
	mtpd_pkg::mac_ctrl_t ctrl;

	logic [AW-1:0]          clr_q;
	logic [TB-1:0]          tap_q;
	logic [AW-1:0]          wp_q;
	logic [AW-1:0]          wcur_q;
	logic [LEN_W-1:0]       len_q;
	logic                   accept;
	logic                   load_out;
	logic                   out_vld_q;
	logic signed [SAMPLE_BITS-1:0] left_q, right_q;
	logic                   clip_q;

	logic [LEN_W-1:0]       len_reg;
	logic [LEN_W-1:0]       len_eff;
	logic [AW-1:0]          wp_eff;
	logic [LEN_W-1:0]       wp_inc;
	logic [AW-1:0]          wp_next;
	logic [FB-1:0]          d_raw;
	logic [LEN_W-1:0]       d_eff;
	logic [LEN_W-1:0]       wc_l;
	logic [LEN_W:0]         wrap_sum;
	logic [AW-1:0]          raddr;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [SAMPLE_BITS-1:0] wdata;
	logic [SAMPLE_BITS-1:0] rdata;
	logic signed [SAMPLE_BITS-1:0] mac_left, mac_right;
	logic                   mac_clip;

	mtpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mtpd_store #(
		.STORE_DEPTH (STORE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	mtpd_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk       (clk),
		.ctrl      (ctrl),
		.sample    ($signed(rdata)),
		.gain      (cfg.tap_gains[{tap_q, 4'b0000} +: FB]),
		.pan       (cfg.tap_pans[{tap_q, 4'b0000} +: FB]),
		.left_out  (mac_left),
		.right_out (mac_right),
		.clipped   (mac_clip)
	);

	// length in use, clamped to 1..STORE_DEPTH
	always_comb begin
		len_reg = LEN_W'(cfg.buffer_length);
		if (len_reg == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_reg > DEPTH_L) begin
			len_eff = DEPTH_L;
		end else begin
			len_eff = len_reg;
		end
	end

	// write position, restarted if the length shrank below it
	always_comb begin
		wp_eff  = (LEN_W'(wp_q) >= len_eff) ? '0 : wp_q;
		wp_inc  = LEN_W'(wp_eff) + LEN_W'(1);
		wp_next = (wp_inc >= len_eff) ? '0 : AW'(wp_inc);
	end

	// tap read address behind the current write position
	always_comb begin
		d_raw = cfg.tap_delays[{tap_q, 4'b0000} +: FB];
		d_eff = (CMP_W'(d_raw) >= CMP_W'(len_q)) ? '0 : LEN_W'(d_raw);
		wc_l  = LEN_W'(wcur_q);
		wrap_sum = (LEN_W + 1)'(wc_l) + (LEN_W + 1)'(len_q) - (LEN_W + 1)'(d_eff);
		if (wc_l >= d_eff) begin
			raddr = AW'(wc_l - d_eff);
		end else begin
			raddr = AW'(wrap_sum);
		end
	end

	assign accept   = sample.valid && sample.ready;
	assign sample.ready = (state_q == mtpd_pkg::ST_IDLE);

	// sequencer next state and controls
	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		we       = 1'b0;
		waddr    = wp_eff;
		wdata    = sample.sample_in;
		load_out = 1'b0;
		case (state_q)
			mtpd_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == CLR_LAST) begin
					state_d = mtpd_pkg::ST_IDLE;
				end
			end
			mtpd_pkg::ST_IDLE: begin
				if (sample.valid) begin
					we       = 1'b1;
					ctrl.clr = 1'b1;
					state_d  = mtpd_pkg::ST_READ;
				end
			end
			mtpd_pkg::ST_READ: begin
				state_d = mtpd_pkg::ST_MUL_GAIN;
			end
			mtpd_pkg::ST_MUL_GAIN: begin
				ctrl.mul_gain = 1'b1;
				state_d       = mtpd_pkg::ST_MUL_PAN;
			end
			mtpd_pkg::ST_MUL_PAN: begin
				ctrl.mul_pan = 1'b1;
				state_d = (tap_q == TAP_LAST) ? mtpd_pkg::ST_FORM : mtpd_pkg::ST_READ;
			end
			mtpd_pkg::ST_FORM: begin
				ctrl.form = 1'b1;
				state_d   = mtpd_pkg::ST_DONE;
			end
			mtpd_pkg::ST_DONE: begin
				if (!out_vld_q || mix.ready) begin
					load_out = 1'b1;
					state_d  = mtpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtpd_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mtpd_pkg::ST_CLEAR;
			clr_q     <= '0;
			tap_q     <= '0;
			wp_q      <= '0;
			wcur_q    <= '0;
			len_q     <= LEN_W'(1);
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mtpd_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				wcur_q <= wp_eff;
				wp_q   <= wp_next;
				len_q  <= len_eff;
				tap_q  <= '0;
			end else if (state_q == mtpd_pkg::ST_MUL_PAN) begin
				tap_q <= tap_q + TB'(1);
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (mix.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			left_q  <= mac_left;
			right_q <= mac_right;
			clip_q  <= mac_clip;
		end
	end

	assign mix.valid     = out_vld_q;
	assign mix.left_out  = left_q;
	assign mix.right_out = right_q;
	assign mix.clipped   = clip_q;

endmodule

FILE: verif/tb_top.sv
module tb_top;

	localparam int DEPTH          = mtpd_pkg::STORE_DEPTH_DEF;
	localparam int TAPS           = mtpd_pkg::TAP_COUNT_DEF;
	localparam int MIX_LATENCY    = 3 * TAPS + 3;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 200;
	localparam int IDLE_PCT       = 21;
	localparam int MAX_REPORTS    = 10;
	localparam int CYCLE_LIMIT    = 500000;
	localparam longint SAMPLE_MAX = 32767;
	localparam longint SAMPLE_MIN = -32768;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               clip;
	} stereo_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [mtpd_pkg::ADDR_BITS-1:0] paddr;
	logic [mtpd_pkg::CFG_BITS-1:0]  pwdata;
	logic [mtpd_pkg::CFG_BITS-1:0]  prdata;
	logic                           pready;

	mtpd_in_if  sample_ch ();
	mtpd_out_if mix_ch ();

	multitap_panned_delay u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (sample_ch),
		.mix     (mix_ch)
	);

	// shadow copy of the delay line and its settings
	logic signed [15:0]            echo_line [DEPTH];
	int unsigned                   echo_wr_pos;
	logic [mtpd_pkg::LEN_BITS-1:0] set_length;
	logic [63:0]                   set_delays;
	logic [63:0]                   set_gains;
	logic [63:0]                   set_pans;

	stereo_t pending_mix [$];
	stereo_t mix_want;
	int      in_idle_pct;
	int      out_idle_pct;
	int      samples_sent;
	int      settings_used;
	int      mix_checked = 0;
	int      mix_clipped = 0;
	int      mix_errors  = 0;
	int      cycle_count = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, pending_mix.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		mix_ch.ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// round the Q.44 sum to Q1.15 and saturate
	function automatic logic signed [15:0] round_q15(input longint acc, inout bit sat);
		longint r;
		r = (acc + (longint'(1) <<< (mtpd_pkg::ROUND_SHIFT - 1))) >>> mtpd_pkg::ROUND_SHIFT;
		if (r > SAMPLE_MAX) begin
			sat = 1'b1;
			return 16'sh7fff;
		end
		if (r < SAMPLE_MIN) begin
			sat = 1'b1;
			return 16'sh8000;
		end
		return 16'(r);
	endfunction

	// write the sample, read the four taps, pan and mix
	function automatic void predict_mix(input logic signed [15:0] s);
		int unsigned        len;
		int unsigned        wp;
		int unsigned        dly;
		int unsigned        pan;
		int unsigned        rd;
		logic signed [15:0] gain;
		longint             prod;
		longint             w_right;
		longint             acc_l;
		longint             acc_r;
		bit                 sat;
		stereo_t            res;
		len = set_length;
		if (len == 0) len = 1;
		if (len > DEPTH) len = DEPTH;
		if (echo_wr_pos >= len) echo_wr_pos = 0;
		wp = echo_wr_pos;
		echo_line[wp] = s;
		acc_l = 0;
		acc_r = 0;
		sat = 1'b0;
		for (int t = 0; t < TAPS; t++) begin
			dly  = set_delays[16*t +: 16];
			gain = set_gains[16*t +: 16];
			pan  = set_pans[16*t +: 16];
			// delay past the length reads the newest sample
			if (dly >= len) dly = 0;
			if (pan > mtpd_pkg::PAN_FULL) pan = mtpd_pkg::PAN_FULL;
			rd = (wp >= dly) ? (wp - dly) : (wp + len - dly);
			prod = longint'(echo_line[rd]) * longint'(gain);
			w_right = longint'(pan);
			acc_l += prod * (longint'(mtpd_pkg::PAN_FULL) - w_right);
			acc_r += prod * w_right;
		end
		echo_wr_pos = wp + 1;
		if (echo_wr_pos >= len) echo_wr_pos = 0;
		res.left  = round_q15(acc_l, sat);
		res.right = round_q15(acc_r, sat);
		res.clip  = sat;
		pending_mix.push_back(res);
	endfunction

	function automatic logic [63:0] pack4(input logic [15:0] t0, input logic [15:0] t1,
		input logic [15:0] t2, input logic [15:0] t3);
		return {t3, t2, t1, t0};
	endfunction

	// register write: setup then access, then the bus goes idle
	task automatic write_reg(input mtpd_pkg::reg_idx_t idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			mtpd_pkg::REG_BUFFER_LENGTH: begin
				set_length = value[mtpd_pkg::LEN_BITS-1:0];
				settings_used++;
			end
			mtpd_pkg::REG_TAP_DELAYS: set_delays = value;
			mtpd_pkg::REG_TAP_GAINS:  set_gains  = value;
			mtpd_pkg::REG_TAP_PANS:   set_pans   = value;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [mtpd_pkg::LEN_BITS-1:0] len,
		input logic [63:0] delays, input logic [63:0] gains, input logic [63:0] pans);
		write_reg(mtpd_pkg::REG_BUFFER_LENGTH, 64'(len));
		write_reg(mtpd_pkg::REG_TAP_DELAYS, delays);
		write_reg(mtpd_pkg::REG_TAP_GAINS, gains);
		write_reg(mtpd_pkg::REG_TAP_PANS, pans);
	endtask

	// send one sample item, predicting its result once taken
	task automatic send_sample(input logic signed [15:0] s);
		while ($urandom_range(99) < in_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.sample_in <= s;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		predict_mix(s);
		samples_sent++;
	endtask

	// stop sending and let every result drain
	task automatic settle_mix();
		sample_ch.valid <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (MIX_LATENCY + 4) @(posedge clk);
	endtask

	// reset settings have zero gain, so the mix is silent
	task automatic test_reset_state();
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh1234);
		settle_mix();
	endtask

	// full scale gains, hard pans and a pan past full right
	task automatic test_tap_extremes();
		write_all(13'd8, pack4(16'd0, 16'd1, 16'd2, 16'd7),
			pack4(16'h7fff, 16'h8000, 16'h4000, 16'hc000),
			pack4(16'd0, 16'd32768, 16'd16384, 16'hffff));
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh0001);
		send_sample(16'shffff);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		settle_mix();
	endtask

	// zero and oversize length, delays past the length, shrinking length
	task automatic test_length_limits();
		write_all(13'd0, pack4(16'd0, 16'd1, 16'hffff, 16'd2),
			pack4(16'h2000, 16'h2000, 16'h2000, 16'h2000),
			pack4(16'd0, 16'd32768, 16'd16384, 16'd40000));
		send_sample(16'sh4000);
		send_sample(16'shc000);
		send_sample(16'sh7fff);
		settle_mix();
		write_reg(mtpd_pkg::REG_BUFFER_LENGTH, 64'd8191);
		write_reg(mtpd_pkg::REG_TAP_DELAYS, pack4(16'd4095, 16'd4096, 16'hffff, 16'd1));
		send_sample(16'sh0100);
		send_sample(16'sh8000);
		send_sample(16'sh2222);
		settle_mix();
		write_reg(mtpd_pkg::REG_BUFFER_LENGTH, 64'd16);
		write_reg(mtpd_pkg::REG_TAP_DELAYS, pack4(16'd0, 16'd3, 16'd15, 16'd16));
		for (int i = 0; i < 7; i++) send_sample(16'($urandom));
		settle_mix();
		// write position now past the new length, restarts at zero
		write_reg(mtpd_pkg::REG_BUFFER_LENGTH, 64'd5);
		send_sample(16'sh7fff);
		send_sample(16'sh8001);
		settle_mix();
	endtask

	// random settings per phase, random samples within
	task automatic test_random_phases();
		int unsigned                   k;
		int unsigned                   eff;
		logic [mtpd_pkg::LEN_BITS-1:0] len;
		logic [63:0]                   delays;
		logic [63:0]                   gains;
		logic [63:0]                   pans;
		logic [15:0]                   s;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			// mostly short lengths so the line wraps often
			k = $urandom_range(99);
			if (k < 50) len = 13'($urandom_range(1, 32));
			else if (k < 75) len = 13'($urandom_range(33, 512));
			else if (k < 85) len = 13'($urandom_range(513, DEPTH));
			else begin
				case ($urandom_range(3))
					0: len = 13'd0;
					1: len = 13'd1;
					2: len = 13'(DEPTH);
					default: len = 13'($urandom_range(DEPTH + 1, 8191));
				endcase
			end
			eff = (len == 0) ? 1 : ((len > DEPTH) ? DEPTH : len);
			for (int t = 0; t < TAPS; t++) begin
				k = $urandom_range(99);
				if (k < 80) delays[16*t +: 16] = 16'($urandom_range(0, eff - 1));
				else if (k < 92) delays[16*t +: 16] = 16'($urandom_range(eff, 65535));
				else delays[16*t +: 16] = 16'($urandom);
				// small gains mostly, so clipping stays occasional
				if ($urandom_range(99) < 60)
					gains[16*t +: 16] = 16'($urandom_range(0, 8192) - 4096);
				else
					gains[16*t +: 16] = 16'($urandom);
				if ($urandom_range(99) < 80)
					pans[16*t +: 16] = 16'($urandom_range(0, mtpd_pkg::PAN_FULL));
				else pans[16*t +: 16] = 16'($urandom);
			end
			write_all(len, delays, gains, pans);
			// one phase runs with no idling on either side
			in_idle_pct  = (ph == 3) ? 0 : IDLE_PCT;
			out_idle_pct = (ph == 3) ? 0 : IDLE_PCT;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 6) begin
					case ($urandom_range(3))
						0: s = 16'h8000;
						1: s = 16'h7fff;
						2: s = 16'h0000;
						default: s = 16'hffff;
					endcase
				end else s = 16'($urandom);
				send_sample(s);
			end
			settle_mix();
		end
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && mix_ch.valid && mix_ch.ready) begin
			mix_checked++;
			if (mix_ch.clipped) mix_clipped++;
			if (pending_mix.size() == 0) begin
				mix_errors++;
				if (mix_errors <= MAX_REPORTS)
					$display("unexpected result %0d: left %0d right %0d clipped %0b",
						mix_checked, mix_ch.left_out, mix_ch.right_out, mix_ch.clipped);
			end else begin
				mix_want = pending_mix.pop_front();
				if (mix_ch.left_out !== mix_want.left || mix_ch.right_out !== mix_want.right ||
					mix_ch.clipped !== mix_want.clip) begin
					mix_errors++;
					if (mix_errors <= MAX_REPORTS)
						$display("result %0d: exp left %0d right %0d clip %0b, got %0d %0d %0b",
							mix_checked, mix_want.left, mix_want.right, mix_want.clip,
							mix_ch.left_out, mix_ch.right_out, mix_ch.clipped);
				end
			end
		end
	end

	initial begin
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		sample_ch.valid     <= 1'b0;
		sample_ch.sample_in <= '0;
		foreach (echo_line[i]) echo_line[i] = '0;
		echo_wr_pos   = 0;
		set_length    = mtpd_pkg::LEN_RESET;
		set_delays    = '0;
		set_gains     = '0;
		set_pans      = '0;
		in_idle_pct   = IDLE_PCT;
		out_idle_pct  = IDLE_PCT;
		samples_sent  = 0;
		settings_used = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_tap_extremes();
		test_length_limits();
		test_random_phases();

		settle_mix();
		$display("covered %0d samples over %0d length settings; %0d stereo results, %0d clipped",
			samples_sent, settings_used, mix_checked, mix_clipped);
		$display("%0d mismatches, %0d results never arrived", mix_errors, pending_mix.size());
		if (mix_errors == 0 && pending_mix.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/mtpd_pkg.sv
design/mtpd_if.sv
design/mtpd_regs.sv
design/mtpd_store.sv
design/mtpd_mac.sv
design/multitap_panned_delay.sv
verif/tb_top.sv
